// ----- design/sgb_pkg.sv -----
// Shared constants, register codes and types of the scaled glyph blitter.
`default_nettype none
package sgb_pkg;
    localparam int GLYPH_SIZE  = 8;
    localparam int SLOT_STRIDE = GLYPH_SIZE + 1;
    localparam int MAX_SCALE   = 8;
    localparam int XW          = 13;   // pixel coordinate width incl. scaled offsets
    localparam int AW          = 33;   // write address width
    localparam int OFFW        = 16;   // x * bytes-per-pixel width
    localparam int SCW         = 4;    // scale value width
    localparam int STW         = 3;    // dx/dy step counter width
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COLOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 3'd4;

    typedef struct packed {
        logic [31:0] frame_base;
        logic [15:0] line_pitch;
        logic [2:0]  pixel_bytes;
        logic [31:0] pixel_color;
        logic [3:0]  scale_factor;
    } t_cfg;

    // One set glyph pixel, ready for expansion.
    typedef struct packed {
        logic [AW-1:0]   row_addr;   // base + y0 * pitch
        logic [OFFW-1:0] x_off;      // x0 * bytes per pixel
        logic [STW-1:0]  scale_m1;
    } t_blit;
endpackage
`default_nettype wire

// ----- design/sgb_if.sv -----
// Channel interfaces: glyph cell input, framebuffer write output, register write.
`default_nettype none
interface sgb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  glyph_slot;
    logic [2:0]  glyph_row;
    logic [2:0]  glyph_col;
    logic [7:0]  row_bits;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    modport source (output valid, glyph_slot, glyph_row, glyph_col, row_bits,
                    origin_x, origin_y, input ready);
    modport sink   (input valid, glyph_slot, glyph_row, glyph_col, row_bits,
                    origin_x, origin_y, output ready);
endinterface

interface sgb_out_if;
    logic        valid;
    logic        ready;
    logic [32:0] write_address;
    logic [31:0] write_data;
    logic        last_write;
    modport source (output valid, write_address, write_data, last_write, input ready);
    modport sink   (input valid, write_address, write_data, last_write, output ready);
endinterface

interface sgb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/sgb_expander.sv -----
// Expands one set glyph pixel into scale x scale framebuffer writes, with output register.
`default_nettype none
module sgb_expander (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  sgb_pkg::t_blit   i_blit,
    input  sgb_pkg::t_cfg    i_cfg,
    sgb_out_if.source        o_out
);
    import sgb_pkg::*;

    logic            r_ex_v;
    logic [STW-1:0]  r_dx, r_dy, r_sm1;
    logic [AW-1:0]   r_row;
    logic [OFFW-1:0] r_xoff, r_xstart;
    logic            r_out_v;
    logic [AW-1:0]   r_out_addr;
    logic [31:0]     r_out_data;
    logic            r_out_last;

    logic out_ld, emit, last, row_end;

    assign out_ld  = !r_out_v || o_out.ready;
    assign emit    = r_ex_v && out_ld;
    assign row_end = (r_dx == r_sm1);
    assign last    = row_end && (r_dy == r_sm1);
    assign o_ready = !r_ex_v || (emit && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_v <= 1'b0;
            r_dx   <= '0;
            r_dy   <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_ex_v <= 1'b1;
                r_dx   <= '0;
                r_dy   <= '0;
            end else if (emit) begin
                if (last) begin
                    r_ex_v <= 1'b0;
                    r_dx   <= '0;
                    r_dy   <= '0;
                end else if (row_end) begin
                    r_dx <= '0;
                    r_dy <= r_dy + 1'b1;
                end else begin
                    r_dx <= r_dx + 1'b1;
                end
            end
        end
    end

    // Running row address and column offset: one add per emitted write.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_row    <= i_blit.row_addr;
            r_xoff   <= i_blit.x_off;
            r_xstart <= i_blit.x_off;
            r_sm1    <= i_blit.scale_m1;
        end else if (emit) begin
            if (row_end) begin
                r_xoff <= r_xstart;
                r_row  <= r_row + AW'(i_cfg.line_pitch);
            end else begin
                r_xoff <= r_xoff + OFFW'(i_cfg.pixel_bytes);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_ld) begin
            r_out_v <= r_ex_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_addr <= r_row + AW'(r_xoff);
            r_out_data <= i_cfg.pixel_color;
            r_out_last <= last;
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.write_address = r_out_addr;
    assign o_out.write_data    = r_out_data;
    assign o_out.last_write    = r_out_last;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ex_v |-> (r_dx <= r_sm1) && (r_dy <= r_sm1))
        else $error("expander step counter past scale");

    a_no_early_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !last) |=> r_ex_v && (r_dx != '0 || r_dy != '0))
        else $error("expansion cut short");

    a_row_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !row_end) |=> (r_dy == $past(r_dy)) && (r_row == $past(r_row)))
        else $error("row advanced mid-row");

    a_out_last_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && last) |=> !r_ex_v || (r_dx == '0 && r_dy == '0))
        else $error("counters not cleared after last write");
endmodule
`default_nettype wire

// ----- design/scaled_glyph_blitter_top.sv -----
// Top level of the scaled glyph blitter: registers, address pipeline, expander.
// A glyph cell whose bit is set produces scale*scale writes (9 at the default
// scale of 3, up to 64), one per cycle at the output port while it is ready; a
// cell whose bit is clear is dropped at the first stage and produces no write.
// Between acceptance and the first write lie a capture stage, a coordinate stage,
// a stage with the y*pitch multiply, the expander and the output register. The
// expander, which adds one pixel step per cycle while the output is ready, sets
// the sustained rate. Registers should be written only while no cell is in
// flight; the register port is always ready.
`default_nettype none
module scaled_glyph_blitter_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sgb_in_if.sink     i_in,
    sgb_cfg_if.sink    i_cfg,
    sgb_out_if.source  o_out
);
    import sgb_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_base   <= 32'd0;
            r_cfg.line_pitch   <= 16'd5120;
            r_cfg.pixel_bytes  <= 3'd4;
            r_cfg.pixel_color  <= 32'h0000_FF00;
            r_cfg.scale_factor <= 4'd3;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_FRAME_BASE:   r_cfg.frame_base   <= i_cfg.data;
                REG_LINE_PITCH:   r_cfg.line_pitch   <= i_cfg.data[15:0];
                REG_PIXEL_BYTES:  r_cfg.pixel_bytes  <= i_cfg.data[2:0];
                REG_PIXEL_COLOR:  r_cfg.pixel_color  <= i_cfg.data;
                REG_SCALE_FACTOR: r_cfg.scale_factor <= i_cfg.data[3:0];
                default: ;
            endcase
        end
    end

    // Zero acts as one, large values saturate.
    logic [SCW-1:0] eff_scale;
    always_comb begin
        priority if (r_cfg.scale_factor == '0)
            eff_scale = SCW'(1);
        else if (r_cfg.scale_factor > SCW'(MAX_SCALE))
            eff_scale = SCW'(MAX_SCALE);
        else
            eff_scale = r_cfg.scale_factor;
    end

    logic s1_ready, s2_ready, s3_ready, ex_ready;
    logic pix_set;

    // Stage 1: capture, drop cells whose bit is clear.
    logic           r_s1_v;
    logic [1:0]     r_s1_slot;
    logic [2:0]     r_s1_row, r_s1_col;
    logic [11:0]    r_s1_ox, r_s1_oy;
    logic [SCW-1:0] r_s1_scale;

    assign pix_set    = i_in.row_bits[3'd7 - i_in.glyph_col];
    assign s1_ready   = !r_s1_v || s2_ready;
    assign i_in.ready = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_ready) begin
            r_s1_v <= i_in.valid && pix_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_slot  <= i_in.glyph_slot;
            r_s1_row   <= i_in.glyph_row;
            r_s1_col   <= i_in.glyph_col;
            r_s1_ox    <= i_in.origin_x;
            r_s1_oy    <= i_in.origin_y;
            r_s1_scale <= eff_scale;
        end
    end

    // Stage 2: pixel coordinates of the square's top-left corner.
    logic           r_s2_v;
    logic [XW-1:0]  r_s2_x, r_s2_y;
    logic [SCW-1:0] r_s2_scale;
    logic [XW-1:0]  slot_x, col_x, row_y;

    assign s2_ready = !r_s2_v || s3_ready;
    assign slot_x   = XW'(r_s1_slot) * XW'(SLOT_STRIDE) * XW'(r_s1_scale);
    assign col_x    = XW'(r_s1_col) * XW'(r_s1_scale);
    assign row_y    = XW'(r_s1_row) * XW'(r_s1_scale);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_ready) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready) begin
            r_s2_x     <= XW'(r_s1_ox) + slot_x + col_x;
            r_s2_y     <= XW'(r_s1_oy) + row_y;
            r_s2_scale <= r_s1_scale;
        end
    end

    // Stage 3: row base address and column byte offset.
    logic  r_s3_v;
    t_blit r_s3_blit;

    assign s3_ready = !r_s3_v || ex_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (s3_ready) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ready) begin
            r_s3_blit.row_addr <= AW'(r_cfg.frame_base)
                                  + AW'(r_s2_y) * AW'(r_cfg.line_pitch);
            r_s3_blit.x_off    <= OFFW'(r_s2_x) * OFFW'(r_cfg.pixel_bytes);
            r_s3_blit.scale_m1 <= STW'(r_s2_scale - SCW'(1));
        end
    end

    sgb_expander u_expander (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_v),
        .o_ready (ex_ready),
        .i_blit  (r_s3_blit),
        .i_cfg   (r_cfg),
        .o_out   (o_out)
    );
endmodule
`default_nettype wire
